### design/lhs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhs_pkg
// Types and constants for the latency histogram statistics block.
// ----------------------------------------------------------------------------
package lhs_pkg;

   localparam int VAL_W   = 10;
   localparam int CNT_W   = 32;
   localparam int LIMIT_W = 11;
   localparam int MEAN_W  = 18;
   localparam int VAR_W   = 28;
   localparam int SQD_W   = 2 * VAL_W;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd800;

   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic [CNT_W-1:0] count;
   } slot_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HOME,
      ST_PROBE_RD,
      ST_PROBE_CHK,
      ST_SCAN,
      ST_DRAIN,
      ST_DIV_MEAN,
      ST_DIV_VAR,
      ST_DONE
   } state_type;

endpackage

### design/latency_histogram_stats_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latency_histogram_stats_top
// Hashed histogram of timing samples with a statistics report.
// ----------------------------------------------------------------------------
// One item at a time. After reset the slot memory is cleared, one slot a
// cycle, while req_stall stays high. An add drops a zero sample or one at or
// above the outlier limit; otherwise it reduces the value to its home slot by
// subtracting SLOTS while the value is at least SLOTS, then reads and checks
// one probed slot after another on the single memory port until a free or
// matching slot is found or every slot has been tried. A report reads every
// slot once, drains a three stage multiply/accumulate pipeline, then, if any
// slot is in use, runs a radix-2 divider twice, for mean and variance, at one
// quotient bit a cycle. Results sit in an output register so the next request
// can be taken while a result waits for rsp_stall to drop.
module latency_histogram_stats_top #(
   parameter int SLOTS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic [lhs_pkg::VAL_W-1:0]     req_sample_value,
   input  logic [lhs_pkg::VAL_W-1:0]     req_mean_value,
   input  logic [lhs_pkg::VAL_W-1:0]     req_miss_threshold,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_sample_stored,
   output logic                          rsp_table_full,
   output logic                          rsp_table_empty,
   output logic [lhs_pkg::VAL_W-1:0]     rsp_mode_value,
   output logic [lhs_pkg::VAL_W-1:0]     rsp_min_value,
   output logic [lhs_pkg::VAL_W-1:0]     rsp_max_value,
   output logic [lhs_pkg::CNT_W-1:0]     rsp_above_threshold_count,
   output logic [lhs_pkg::CNT_W-1:0]     rsp_total_count,
   output logic [lhs_pkg::MEAN_W-1:0]    rsp_mean_fixed,
   output logic [lhs_pkg::VAR_W-1:0]     rsp_variance_fixed,
   input  logic                          csr_wr_en,
   input  logic [lhs_pkg::LIMIT_W-1:0]   csr_wr_data
);
   import lhs_pkg::*;

   localparam int IDX_W   = $clog2(SLOTS);
   localparam int ACC_W   = CNT_W + IDX_W;
   localparam int VC_W    = VAL_W + CNT_W;
   localparam int SUM_W   = VC_W + IDX_W;
   localparam int SQ1_W   = SQD_W + CNT_W;
   localparam int SQ_W    = SQ1_W + IDX_W;
   localparam int DIVN_W  = SQ_W + 8;
   localparam int DCNT_W  = $clog2(DIVN_W + 1);
   localparam int TRY_W   = IDX_W + 1;

   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [TRY_W-1:0]  NUM_SLOTS = TRY_W'(SLOTS);
   localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIVN_W - 1);

   state_type state_ff, state_in;

   // slot memory
   slot_type   mem [SLOTS];
   slot_type   rd_data_ff;
   logic       mem_we;
   logic [IDX_W-1:0] mem_addr;
   slot_type   mem_wdata;

   logic [LIMIT_W-1:0] limit_ff;

   logic             op_ff;
   logic [VAL_W-1:0] sample_ff;
   logic [VAL_W-1:0] mean_ff;
   logic [VAL_W-1:0] thr_ff;
   logic [VAL_W-1:0] home_ff;
   logic [IDX_W-1:0] probe_ff;
   logic [TRY_W-1:0] tries_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             stored_ff;
   logic             full_ff;

   // scan pipeline
   logic             p0_ff;
   logic             a_vld_ff;
   logic [VAL_W-1:0] a_v_ff;
   logic [CNT_W-1:0] a_c_ff;
   logic [SQD_W-1:0] a_dd_ff;
   logic [VC_W-1:0]  a_vc_ff;
   logic             b_vld_ff;
   logic [VAL_W-1:0] b_v_ff;
   logic [CNT_W-1:0] b_c_ff;
   logic [VC_W-1:0]  b_vc_ff;
   logic [SQ1_W-1:0] b_sq_ff;

   logic             any_ff;
   logic [CNT_W-1:0] best_ff;
   logic [VAL_W-1:0] mode_ff;
   logic [VAL_W-1:0] min_ff;
   logic [VAL_W-1:0] max_ff;
   logic [ACC_W-1:0] total_ff;
   logic [ACC_W-1:0] above_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [SQ_W-1:0]  sq_ff;

   // divider
   logic [DIVN_W-1:0] dnum_ff;
   logic [ACC_W-1:0]  drem_ff;
   logic [VAR_W-1:0]  dq_ff;
   logic              dovf_ff;
   logic [DCNT_W-1:0] dcnt_ff;
   logic [MEAN_W-1:0] meanq_ff;
   logic [ACC_W:0]    drem_sh;
   logic [ACC_W:0]    drem_sub;
   logic              dbit;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_load;
   logic             req_xfer;
   logic             slot_hit;
   logic [VAL_W-1:0] abs_dev;
   logic             drained;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign slot_hit  = (rd_data_ff.value == '0) || (rd_data_ff.value == sample_ff);
   assign drained   = !p0_ff && !a_vld_ff && !b_vld_ff;
   assign abs_dev   = (rd_data_ff.value >= mean_ff) ? rd_data_ff.value - mean_ff
                                                   : mean_ff - rd_data_ff.value;
   assign drem_sh   = {drem_ff, dnum_ff[DIVN_W-1]};
   assign drem_sub  = drem_sh - {1'b0, total_ff};
   assign dbit      = (drem_sh >= {1'b0, total_ff});

   // memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      mem_we       = 1'b0;
      mem_addr     = probe_ff;
      mem_wdata    = '0;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = idx_ff;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_op == OP_REPORT) begin
                  state_in = ST_SCAN;
               end else if (req_sample_value == '0 ||
                            {1'b0, req_sample_value} >= limit_ff) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_HOME;
               end
            end
         end
         ST_HOME: begin
            if (32'(home_ff) < 32'(SLOTS)) begin
               state_in = ST_PROBE_RD;
            end
         end
         ST_PROBE_RD: begin
            state_in = ST_PROBE_CHK;
         end
         ST_PROBE_CHK: begin
            if (slot_hit) begin
               mem_we          = 1'b1;
               mem_wdata.value = sample_ff;
               mem_wdata.count = (rd_data_ff.count == '1) ? rd_data_ff.count
                                                          : rd_data_ff.count + 1'b1;
               state_in        = ST_DONE;
            end else if (tries_ff + 1'b1 == NUM_SLOTS) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_PROBE_RD;
            end
         end
         ST_SCAN: begin
            mem_addr = idx_ff;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (drained) begin
               state_in = any_ff ? ST_DIV_MEAN : ST_DONE;
            end
         end
         ST_DIV_MEAN: begin
            if (dcnt_ff == DIV_LAST) begin
               state_in = ST_DIV_VAR;
            end
         end
         ST_DIV_VAR: begin
            if (dcnt_ff == DIV_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         p0_ff    <= 1'b0;
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         p0_ff    <= (state_ff == ST_SCAN);
         a_vld_ff <= p0_ff && (rd_data_ff.value != '0);
         b_vld_ff <= a_vld_ff;
         if (state_ff == ST_CLEAR || state_ff == ST_SCAN) begin
            idx_ff <= (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
         end
      end

      a_v_ff  <= rd_data_ff.value;
      a_c_ff  <= rd_data_ff.count;
      a_dd_ff <= SQD_W'(abs_dev) * SQD_W'(abs_dev);
      a_vc_ff <= VC_W'(rd_data_ff.value) * VC_W'(rd_data_ff.count);
      b_v_ff  <= a_v_ff;
      b_c_ff  <= a_c_ff;
      b_vc_ff <= a_vc_ff;
      b_sq_ff <= SQ1_W'(a_dd_ff) * SQ1_W'(a_c_ff);

      if (req_xfer) begin
         op_ff     <= req_op;
         sample_ff <= req_sample_value;
         mean_ff   <= req_mean_value;
         thr_ff    <= req_miss_threshold;
         home_ff   <= req_sample_value;
         tries_ff  <= '0;
         stored_ff <= 1'b0;
         full_ff   <= 1'b0;
         any_ff    <= 1'b0;
         best_ff   <= '0;
         mode_ff   <= '0;
         min_ff    <= '0;
         max_ff    <= '0;
         total_ff  <= '0;
         above_ff  <= '0;
         sum_ff    <= '0;
         sq_ff     <= '0;
      end

      if (state_ff == ST_HOME) begin
         if (32'(home_ff) >= 32'(SLOTS)) begin
            home_ff <= home_ff - VAL_W'(SLOTS);
         end else begin
            probe_ff <= IDX_W'(home_ff);
         end
      end

      if (state_ff == ST_PROBE_CHK) begin
         if (slot_hit) begin
            stored_ff <= 1'b1;
         end else begin
            tries_ff <= tries_ff + 1'b1;
            probe_ff <= (probe_ff == LAST_IDX) ? '0 : probe_ff + 1'b1;
            if (tries_ff + 1'b1 == NUM_SLOTS) begin
               full_ff <= 1'b1;
            end
         end
      end

      if (b_vld_ff) begin
         any_ff   <= 1'b1;
         total_ff <= total_ff + ACC_W'(b_c_ff);
         sum_ff   <= sum_ff + SUM_W'(b_vc_ff);
         sq_ff    <= sq_ff + SQ_W'(b_sq_ff);
         if (b_v_ff > thr_ff) begin
            above_ff <= above_ff + ACC_W'(b_c_ff);
         end
         if (b_c_ff > best_ff) begin
            best_ff <= b_c_ff;
            mode_ff <= b_v_ff;
         end
         if (!any_ff || b_v_ff < min_ff) begin
            min_ff <= b_v_ff;
         end
         if (!any_ff || b_v_ff > max_ff) begin
            max_ff <= b_v_ff;
         end
      end

      if (state_ff == ST_DRAIN) begin
         dnum_ff <= DIVN_W'({sum_ff, 8'h00});
         drem_ff <= '0;
         dq_ff   <= '0;
         dovf_ff <= 1'b0;
         dcnt_ff <= '0;
      end else if (state_ff == ST_DIV_MEAN || state_ff == ST_DIV_VAR) begin
         if (dcnt_ff == DIV_LAST && state_ff == ST_DIV_MEAN) begin
            meanq_ff <= MEAN_W'({dq_ff, dbit});
            dnum_ff  <= {sq_ff, 8'h00};
            drem_ff  <= '0;
            dq_ff    <= '0;
            dovf_ff  <= 1'b0;
            dcnt_ff  <= '0;
         end else begin
            dnum_ff <= {dnum_ff[DIVN_W-2:0], 1'b0};
            drem_ff <= dbit ? drem_sub[ACC_W-1:0] : drem_sh[ACC_W-1:0];
            dq_ff   <= {dq_ff[VAR_W-2:0], dbit};
            dovf_ff <= dovf_ff | dq_ff[VAR_W-1];
            dcnt_ff <= dcnt_ff + 1'b1;
         end
      end

      if (rsp_load) begin
         if (op_ff == OP_ADD) begin
            rsp_sample_stored <= stored_ff;
            rsp_table_full    <= full_ff;
         end else begin
            rsp_sample_stored <= 1'b0;
            rsp_table_full    <= 1'b0;
         end
         rsp_table_empty <= (op_ff == OP_REPORT) && !any_ff;
         if (op_ff == OP_REPORT && any_ff) begin
            rsp_mode_value <= mode_ff;
            rsp_min_value  <= min_ff;
            rsp_max_value  <= max_ff;
            rsp_above_threshold_count <= (above_ff[ACC_W-1:CNT_W] != '0) ? '1
                                         : above_ff[CNT_W-1:0];
            rsp_total_count <= (total_ff[ACC_W-1:CNT_W] != '0) ? '1
                               : total_ff[CNT_W-1:0];
            rsp_mean_fixed     <= meanq_ff;
            rsp_variance_fixed <= dovf_ff ? '1 : dq_ff;
         end else begin
            rsp_mode_value    <= '0;
            rsp_min_value     <= '0;
            rsp_max_value     <= '0;
            rsp_above_threshold_count <= '0;
            rsp_total_count   <= '0;
            rsp_mean_fixed    <= '0;
            rsp_variance_fixed <= '0;
         end
      end
   end

endmodule

### dv/latency_histogram_stats_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latency_histogram_stats_top_tb
// Drives add and report transfers through the histogram block over several
// outlier limit settings with random idling on both channels and one long
// receiver hold-off. A scoreboard keeps its own copy of the slot table and
// checks every result field by field.
// ----------------------------------------------------------------------------
module latency_histogram_stats_top_tb;
   import lhs_pkg::*;

   localparam int TABLE_SLOTS = 1024;

   typedef struct {
      logic              stored;
      logic              full;
      logic              empty;
      logic [VAL_W-1:0]  mode;
      logic [VAL_W-1:0]  min_v;
      logic [VAL_W-1:0]  max_v;
      logic [CNT_W-1:0]  above;
      logic [CNT_W-1:0]  total;
      logic [MEAN_W-1:0] mean;
      logic [VAR_W-1:0]  variance;
   } stats_result_type;

   class histogram_scoreboard;
      logic [LIMIT_W-1:0] limit;
      logic [VAL_W-1:0]   slot_val[TABLE_SLOTS];
      logic [CNT_W-1:0]   slot_cnt[TABLE_SLOTS];
      stats_result_type   expected_q[$];
      int                 errors;

      function new();
         limit = LIMIT_RESET;
         errors = 0;
         foreach (slot_val[i]) begin
            slot_val[i] = '0;
            slot_cnt[i] = '0;
         end
      endfunction

      function longint unsigned fixed8_div(longint unsigned num, longint unsigned den);
         return ((num / den) << 8) + (((num % den) << 8) / den);
      endfunction

      function void note_transfer(logic op, logic [VAL_W-1:0] sample,
                                  logic [VAL_W-1:0] mean_in, logic [VAL_W-1:0] thr);
         stats_result_type r;
         int slot;
         bit any;
         longint unsigned total, above, sum, sq, d, best, var_q;
         r = '{default: '0};
         if (op == OP_ADD) begin
            if (sample != 0 && {1'b0, sample} < limit) begin
               r.full = 1'b1;
               for (int i = 0; i < TABLE_SLOTS; i++) begin
                  slot = (int'(sample) + i) % TABLE_SLOTS;
                  if (slot_val[slot] == 0 || slot_val[slot] == sample) begin
                     slot_val[slot] = sample;
                     if (slot_cnt[slot] != '1) slot_cnt[slot]++;
                     r.stored = 1'b1;
                     r.full = 1'b0;
                     break;
                  end
               end
            end
         end else begin
            any = 0;
            total = 0; above = 0; sum = 0; sq = 0; best = 0;
            for (int i = 0; i < TABLE_SLOTS; i++) begin
               if (slot_val[i] == 0) continue;
               if (slot_cnt[i] > best) begin
                  best = slot_cnt[i];
                  r.mode = slot_val[i];
               end
               if (!any || slot_val[i] < r.min_v) r.min_v = slot_val[i];
               if (!any || slot_val[i] > r.max_v) r.max_v = slot_val[i];
               any = 1;
               total += slot_cnt[i];
               if (slot_val[i] > thr) above += slot_cnt[i];
               sum += longint'(slot_val[i]) * slot_cnt[i];
               d = (slot_val[i] >= mean_in) ? slot_val[i] - mean_in : mean_in - slot_val[i];
               sq += d * d * slot_cnt[i];
            end
            if (!any || total == 0) begin
               r = '{default: '0};
               r.empty = 1'b1;
            end else begin
               r.above = (above > 64'hFFFF_FFFF) ? '1 : above[CNT_W-1:0];
               r.total = (total > 64'hFFFF_FFFF) ? '1 : total[CNT_W-1:0];
               r.mean = MEAN_W'(fixed8_div(sum, total));
               var_q = fixed8_div(sq, total);
               r.variance = (var_q > 64'h0FFF_FFFF) ? '1 : var_q[VAR_W-1:0];
            end
         end
         expected_q.push_back(r);
      endfunction

      function void compare(string name, longint unsigned exp_v, longint unsigned got_v);
         if (exp_v != got_v) begin
            errors++;
            $display("%0t: mismatch %s expected %0d actual %0d", $time, name, exp_v, got_v);
         end
      endfunction

      function void check_result(stats_result_type got);
         stats_result_type e;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result transfer", $time);
            return;
         end
         e = expected_q.pop_front();
         compare("sample_stored", e.stored, got.stored);
         compare("table_full", e.full, got.full);
         compare("table_empty", e.empty, got.empty);
         compare("mode_value", e.mode, got.mode);
         compare("min_value", e.min_v, got.min_v);
         compare("max_value", e.max_v, got.max_v);
         compare("above_threshold_count", e.above, got.above);
         compare("total_count", e.total, got.total);
         compare("mean_fixed", e.mean, got.mean);
         compare("variance_fixed", e.variance, got.variance);
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_op = OP_ADD;
   logic [VAL_W-1:0]    req_sample_value = '0;
   logic [VAL_W-1:0]    req_mean_value = '0;
   logic [VAL_W-1:0]    req_miss_threshold = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_sample_stored;
   logic                rsp_table_full;
   logic                rsp_table_empty;
   logic [VAL_W-1:0]    rsp_mode_value;
   logic [VAL_W-1:0]    rsp_min_value;
   logic [VAL_W-1:0]    rsp_max_value;
   logic [CNT_W-1:0]    rsp_above_threshold_count;
   logic [CNT_W-1:0]    rsp_total_count;
   logic [MEAN_W-1:0]   rsp_mean_fixed;
   logic [VAR_W-1:0]    rsp_variance_fixed;
   logic                csr_wr_en = 1'b0;
   logic [LIMIT_W-1:0]  csr_wr_data = '0;

   histogram_scoreboard hist_sb = new();
   bit                  quiet = 0;
   bit                  hold_request = 0;
   logic [VAL_W-1:0]    sample_pool[24];

   latency_histogram_stats_top dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result side: monitor and stall bursts
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         hist_sb.check_result('{rsp_sample_stored, rsp_table_full, rsp_table_empty,
                               rsp_mode_value, rsp_min_value, rsp_max_value,
                               rsp_above_threshold_count, rsp_total_count,
                               rsp_mean_fixed, rsp_variance_fixed});
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_request = 0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_transfer(logic op, logic [VAL_W-1:0] sample,
                                logic [VAL_W-1:0] mean_in, logic [VAL_W-1:0] thr);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_sample_value <= sample;
      req_mean_value <= mean_in;
      req_miss_threshold <= thr;
      do @(posedge clock); while (req_stall);
      hist_sb.note_transfer(op, sample, mean_in, thr);
   endtask

   task automatic write_limit(logic [LIMIT_W-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (hist_sb.expected_q.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      hist_sb.limit = value;
   endtask

   task automatic random_phase(int items);
      logic [VAL_W-1:0] sample;
      foreach (sample_pool[i]) sample_pool[i] = VAL_W'($urandom_range(1, 1023));
      for (int n = 0; n < items; n++) begin
         if ($urandom_range(0, 11) == 0) begin
            send_transfer(OP_REPORT, VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
         end else begin
            sample = ($urandom_range(0, 4) == 0) ? VAL_W'($urandom)
                                                 : sample_pool[$urandom_range(0, 23)];
            send_transfer(OP_ADD, sample, VAL_W'($urandom), VAL_W'($urandom));
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (req_stall);

      // directed: empty table, drops, extremes
      write_limit(LIMIT_RESET);
      send_transfer(OP_REPORT, 10'd0, 10'd0, 10'd0);
      send_transfer(OP_ADD, 10'd0, 10'd0, 10'd0);
      send_transfer(OP_ADD, 10'd1, 10'h3FF, 10'h3FF);
      send_transfer(OP_ADD, 10'd1023, 10'd0, 10'd0);
      send_transfer(OP_ADD, 10'd800, 10'd0, 10'd0);
      send_transfer(OP_ADD, 10'd799, 10'd0, 10'd0);
      send_transfer(OP_ADD, 10'd799, 10'd0, 10'd0);
      send_transfer(OP_REPORT, 10'd0, 10'd0, 10'd0);
      send_transfer(OP_REPORT, 10'd1023, 10'd1023, 10'd1023);
      send_transfer(OP_REPORT, 10'd0, 10'd1, 10'd798);
      write_limit(11'd1024);
      send_transfer(OP_ADD, 10'd1023, 10'd0, 10'd0);
      send_transfer(OP_ADD, 10'd1, 10'd0, 10'd0);
      send_transfer(OP_REPORT, 10'd0, 10'd0, 10'd1022);
      write_limit(11'd0);
      send_transfer(OP_ADD, 10'd5, 10'd0, 10'd0);
      write_limit(11'd1);
      send_transfer(OP_ADD, 10'd1, 10'd0, 10'd0);
      send_transfer(OP_REPORT, 10'd512, 10'd512, 10'd0);

      write_limit(LIMIT_RESET);
      random_phase(150);
      write_limit(11'd1);
      random_phase(60);
      write_limit(11'd0);
      random_phase(60);
      write_limit(11'd2047);
      hold_request = 1;
      random_phase(200);
      write_limit(11'd1024);
      random_phase(200);
      write_limit(11'd500);
      random_phase(150);
      write_limit(LIMIT_W'($urandom_range(1, 1024)));
      quiet = 1;
      random_phase(130);

      req_valid <= 1'b0;
      while (hist_sb.expected_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (hist_sb.errors == 0)
         $display("latency_histogram_stats_top regression: pass");
      else
         $display("latency_histogram_stats_top regression: fail");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("latency_histogram_stats_top regression: fail");
      $finish;
   end

endmodule
